@@ design/hraa_pkg.sv @@
// Shared constants, types and codes for the heart-rate average and alarm block.
package hraa_pkg;

    // Window length and derived widths
    localparam int WINDOW    = 200;
    localparam int PTR_W     = $clog2(WINDOW);
    localparam int SUM_W     = $clog2(WINDOW * 255 + 1);

    // Divide by WINDOW as multiply by a rounded-up reciprocal; exact for any sum below 2**SUM_W
    localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW);
    localparam int RECIP     = ((2 ** DIV_SHIFT) + WINDOW - 1) / WINDOW;
    localparam int RECIP_W   = $clog2(RECIP + 1);
    localparam int PROD_W    = SUM_W + RECIP_W;

    // Field widths
    localparam int HR_W      = 11;
    localparam int RATE_W    = 8;
    localparam int CNT_W     = 8;

    // Stream and configuration port widths
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_IDX_W   = 8;

    // No-estimate code
    localparam logic signed [HR_W-1:0] NO_ESTIMATE = -11'sd999;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RATE    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERSISTENCE = 8'd3;

    // Configuration reset values
    localparam logic [RATE_W-1:0] RST_MIN_RATE    = 8'd50;
    localparam logic [RATE_W-1:0] RST_MAX_RATE    = 8'd130;
    localparam logic [RATE_W-1:0] RST_THRESHOLD   = 8'd10;
    localparam logic [CNT_W-1:0]  RST_PERSISTENCE = 8'd1;

    // Result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Window stage result
    typedef struct packed {
        logic              ready;
        logic [RATE_W-1:0] average;
        logic [RATE_W-1:0] held;
        logic [RATE_W-1:0] qualified;
    } t_win_res;

    // Full result item, qualified rate in the lowest bits
    typedef struct packed {
        logic              alarm;
        logic [RATE_W-1:0] average;
        logic              ready;
        logic [RATE_W-1:0] held;
        logic [RATE_W-1:0] qualified;
    } t_result;

endpackage

@@ design/hraa_ram.sv @@
// Generic single-clock RAM, one write port and one registered read port (read-first).
module hraa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/hraa_avg.sv @@
// Qualification, window ring, running sum and divide pipeline.
module hraa_avg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic signed [hraa_pkg::HR_W-1:0] i_heart_rate,
    input  logic [hraa_pkg::RATE_W-1:0]     i_min_rate,
    input  logic [hraa_pkg::RATE_W-1:0]     i_max_rate,
    output logic                            o_valid,
    output hraa_pkg::t_win_res              o_res
);
    import hraa_pkg::*;

    // Stage 0 state
    logic [PTR_W-1:0]  r_wp, n_wp;
    logic              r_full, n_full;
    logic [RATE_W-1:0] r_held, n_held;
    logic [RATE_W-1:0] q0;
    logic              is_none, in_range, wrap;

    // Stage 1
    logic              r_v1, r_sub1, r_rdy1;
    logic [RATE_W-1:0] r_q1, r_held1;
    logic [RATE_W-1:0] ram_rdata;
    logic [SUM_W-1:0]  r_sum, n_sum, old_term;

    // Stage 2
    logic              r_v2, r_rdy2;
    logic [RATE_W-1:0] r_q2, r_held2;

    // Stage 3
    logic              r_v3, r_rdy3;
    logic [RATE_W-1:0] r_q3, r_held3;
    logic [PROD_W-1:0] r_prod;

    always_comb begin
        is_none  = (i_heart_rate == NO_ESTIMATE);
        in_range = (i_heart_rate >= $signed({{(HR_W-RATE_W){1'b0}}, i_min_rate}))
                && (i_heart_rate <= $signed({{(HR_W-RATE_W){1'b0}}, i_max_rate}));
        n_held = r_held;
        if (is_none) begin
            q0 = '0;
        end else if (in_range) begin
            q0     = i_heart_rate[RATE_W-1:0];
            n_held = i_heart_rate[RATE_W-1:0];
        end else begin
            q0 = r_held;
        end
        wrap   = (r_wp == PTR_W'(WINDOW - 1));
        n_wp   = wrap ? '0 : r_wp + 1'b1;
        n_full = r_full | wrap;
    end

    // Oldest entry sits at the write address; read-first gives its old value
    hraa_ram #(
        .WIDTH(RATE_W),
        .DEPTH(WINDOW)
    ) u_window (
        .i_clk  (i_clk),
        .i_we   (i_valid),
        .i_waddr(r_wp),
        .i_wdata(q0),
        .i_re   (i_valid),
        .i_raddr(r_wp),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        old_term = r_sub1 ? SUM_W'(ram_rdata) : '0;
        n_sum    = r_sum - old_term + SUM_W'(r_q1);
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_full <= 1'b0;
            r_held <= '0;
            r_sum  <= '0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (i_valid) begin
                r_wp   <= n_wp;
                r_full <= n_full;
                r_held <= n_held;
            end
            if (r_v1) begin
                r_sum <= n_sum;
            end
        end
    end

    // Payload pipeline
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_q1    <= q0;
            r_held1 <= n_held;
            r_sub1  <= r_full;
            r_rdy1  <= n_full;
        end
        if (r_v1) begin
            r_q2    <= r_q1;
            r_held2 <= r_held1;
            r_rdy2  <= r_rdy1;
        end
        if (r_v2) begin
            r_q3    <= r_q2;
            r_held3 <= r_held2;
            r_rdy3  <= r_rdy2;
            r_prod  <= PROD_W'(r_sum) * PROD_W'(RECIP);
        end
    end

    assign o_valid         = r_v3;
    assign o_res.qualified = r_q3;
    assign o_res.held      = r_held3;
    assign o_res.ready     = r_rdy3;
    assign o_res.average   = r_rdy3 ? r_prod[DIV_SHIFT +: RATE_W] : '0;

`ifndef NO_ASSERTIONS
    a_sum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum <= SUM_W'(WINDOW * 255))
        else $error("window sum beyond full-scale");
    a_full_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |=> r_full)
        else $error("window full flag dropped");
`endif

endmodule

@@ design/hraa_alarm.sv @@
// Warning counter and alarm latch stage.
module hraa_alarm (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  hraa_pkg::t_win_res          i_res,
    input  logic [hraa_pkg::RATE_W-1:0] i_threshold,
    input  logic [hraa_pkg::CNT_W-1:0]  i_persistence,
    output logic                        o_valid,
    output hraa_pkg::t_result           o_result
);
    import hraa_pkg::*;

    logic [CNT_W-1:0] r_cnt, n_cnt, cnt_tmp;
    logic             r_alarm, n_alarm;

    always_comb begin
        n_alarm = r_alarm;
        n_cnt   = r_cnt;
        cnt_tmp = r_cnt;
        if (i_valid && i_res.ready) begin
            if (r_cnt == i_persistence) begin
                n_alarm = 1'b1;
                cnt_tmp = '0;
            end
            if (i_res.average >= i_threshold) begin
                // hold at full scale
                n_cnt = (cnt_tmp != '1) ? cnt_tmp + 1'b1 : cnt_tmp;
            end else begin
                n_cnt = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_alarm <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_alarm <= n_alarm;
        end
    end

    assign o_valid            = i_valid;
    assign o_result.qualified = i_res.qualified;
    assign o_result.held      = i_res.held;
    assign o_result.ready     = i_res.ready;
    assign o_result.average   = i_res.average;
    assign o_result.alarm     = n_alarm;

`ifndef NO_ASSERTIONS
    a_alarm_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alarm |=> r_alarm)
        else $error("alarm latch cleared without reset");
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_valid && i_res.ready) |=> $stable(r_cnt))
        else $error("warning count moved without a ready result");
`endif

endmodule

@@ design/hraa_fifo.sv @@
// Result queue decoupling the pipeline from the output handshake.
module hraa_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  hraa_pkg::t_result i_data,
    input  logic              i_pop,
    output logic              o_valid,
    output hraa_pkg::t_result o_data
);
    import hraa_pkg::*;

    t_result               r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr, r_rd;
    logic [FIFO_CNT_W-1:0] r_cnt;
    logic                  do_pop;

    assign do_pop  = i_pop && (r_cnt != '0);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == FIFO_CNT_W'(FIFO_DEPTH)) |-> (!i_push || do_pop))
        else $error("result queue overflow");
`endif

endmodule

@@ design/heart_rate_average_alarm.sv @@
// Top level of the heart-rate moving average and alarm block.
//
//  channel   direction  handshake                   payload
//  s_axis    in         s_axis_tvalid/tready        heart_rate (11b signed)
//  m_axis    out        m_axis_tvalid/tready        qualified, held, ready, average, alarm
//  cfg       in         i_cfg_valid/o_cfg_ready     index (8b), data (8b)
//
// One estimate is taken per cycle while s_axis_tready is high; a result is offered on m_axis
// once it has passed the average pipeline registers, the alarm stage and the queue.
// The window RAM lets each item read the oldest entry and write the new one at the same
// address in the same cycle.
// Reset clears pointer, sum, held value, counter and alarm at once; the RAM needs no
// clearing pass because no entry is subtracted before the ring has filled.
// Input is held off only when eight results are outstanding (queue plus pipeline).
module heart_rate_average_alarm (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // heart_rate in [10:0], upper bits zero
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [hraa_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // qualified_rate [7:0], held_rate [15:8], average_ready [16],
    // average_rate [24:17], alarm [25], upper bits zero
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [hraa_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [hraa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [hraa_pkg::RATE_W-1:0]        i_cfg_data
);
    import hraa_pkg::*;

    // Configuration registers
    logic [RATE_W-1:0] r_min_rate, r_max_rate, r_threshold;
    logic [CNT_W-1:0]  r_persistence;

    // Transfer tracking
    logic                  in_xfer, out_xfer;
    logic [FIFO_CNT_W-1:0] r_outstanding;

    // Internal links
    logic     win_valid, alm_valid;
    t_win_res win_res;
    t_result  alm_result, fifo_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_rate    <= RST_MIN_RATE;
            r_max_rate    <= RST_MAX_RATE;
            r_threshold   <= RST_THRESHOLD;
            r_persistence <= RST_PERSISTENCE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MIN_RATE:    r_min_rate    <= i_cfg_data;
                CFG_MAX_RATE:    r_max_rate    <= i_cfg_data;
                CFG_THRESHOLD:   r_threshold   <= i_cfg_data;
                CFG_PERSISTENCE: r_persistence <= i_cfg_data;
                default:         r_min_rate    <= r_min_rate; // drop unknown index
            endcase
        end
    end

    // Accept while fewer results are outstanding than the queue can hold
    assign s_axis_tready = (r_outstanding != FIFO_CNT_W'(FIFO_DEPTH));
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_xfer      = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            case ({in_xfer, out_xfer})
                2'b10:   r_outstanding <= r_outstanding + 1'b1;
                2'b01:   r_outstanding <= r_outstanding - 1'b1;
                default: r_outstanding <= r_outstanding;
            endcase
        end
    end

    hraa_avg u_avg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_xfer),
        .i_heart_rate($signed(s_axis_tdata[HR_W-1:0])),
        .i_min_rate  (r_min_rate),
        .i_max_rate  (r_max_rate),
        .o_valid     (win_valid),
        .o_res       (win_res)
    );

    hraa_alarm u_alarm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (win_valid),
        .i_res        (win_res),
        .i_threshold  (r_threshold),
        .i_persistence(r_persistence),
        .o_valid      (alm_valid),
        .o_result     (alm_result)
    );

    hraa_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (alm_valid),
        .i_data (alm_result),
        .i_pop  (m_axis_tready),
        .o_valid(m_axis_tvalid),
        .o_data (fifo_data)
    );

    assign m_axis_tdata = OUT_TDATA_W'(fifo_data);

`ifndef NO_ASSERTIONS
    a_outstanding_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outstanding <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("outstanding count beyond queue depth");
`endif

endmodule
